>>> rtl/core/cpgv_pkg.sv
// Package for the coil pulse and gate velocity block.
// Holds phase codes, register indexes, reset values and the controller/datapath
// command and status types. Depends on nothing.
package cpgv_pkg;

   localparam int unsigned VEL_W   = 16;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_FIRING  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_STOPPED = 3'd2;
   localparam logic [PHASE_W-1:0] PH_WAITING = 3'd3;
   localparam logic [PHASE_W-1:0] PH_CALC    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_ON_TIME = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPACING = 8'd1;

   localparam logic [15:0] ON_TIME_RESET = 16'd2000;
   localparam logic [7:0]  SPACING_RESET = 8'd20;
   localparam logic [VEL_W-1:0] VEL_MAX  = 16'hFFFF;

   typedef struct packed {
      logic step;
      logic div_load;
      logic div_step;
      logic div_done;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic calc_due;
   } status_type;

endpackage

>>> rtl/core/coil_pulse_and_gate_velocity_fsm.sv
// Top level of the coil pulse and gate velocity block.
// Instantiates cpgv_ctrl and cpgv_datapath; depends on cpgv_pkg.
//
// Each request on the req_ channel is one millisecond tick carrying the fire
// button and the two light-gate levels. Every request gives exactly one
// response on the rsp_ channel with the coil drive, the phase, the last
// measured velocity (unsigned, VELOCITY_FRACTION_BITS fraction bits,
// saturated at 65535) and a flag marking a freshly computed velocity.
// A tick that needs no division passes from idle through the wait state into
// the output register, and the next request can be taken when it is loaded.
// A tick that completes a measurement first runs the serial restoring divider,
// which forms 8 + VELOCITY_FRACTION_BITS quotient bits, one per cycle.
// Requests are processed one at a time; the response sits in an output
// register, so a further request is taken while a response waits. If the
// receiver stalls, a second finished response waits inside the block and no
// more requests are taken until the output register frees.
// The csr_ port writes the on-time limit (index 0) and gate spacing (index 1)
// and is always ready. Synchronous reset returns the controller and phase machine
// to idle with on-time 2000 ms, spacing 20 mm and the tick counter at zero.
module coil_pulse_and_gate_velocity_fsm #(
   parameter int unsigned TIME_WIDTH             = 32,
   parameter int unsigned VELOCITY_FRACTION_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] button_pressed, [1] gate1_blocked, [2] gate2_blocked, [7:3] zero.
   input  logic [7:0]                          req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] coil_on, [3:1] phase, [19:4] velocity_q8, [20] velocity_fresh, [23:21] zero.
   output logic [23:0]                         rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cpgv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cpgv_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   cpgv_pkg::cmd_type            cmd;
   cpgv_pkg::status_type         status;
   logic                         coil_on;
   logic [cpgv_pkg::PHASE_W-1:0] phase;
   logic [cpgv_pkg::VEL_W-1:0]   velocity_q8;
   logic                         velocity_fresh;

   assign csr_ready = 1'b1;

   cpgv_ctrl #(
      .DIV_STEPS (8 + VELOCITY_FRACTION_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cpgv_datapath #(
      .TIME_WIDTH             (TIME_WIDTH),
      .VELOCITY_FRACTION_BITS (VELOCITY_FRACTION_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .button_pressed (req_tdata[0]),
      .gate1_blocked  (req_tdata[1]),
      .gate2_blocked  (req_tdata[2]),
      .cmd            (cmd),
      .status         (status),
      .coil_on        (coil_on),
      .phase          (phase),
      .velocity_q8    (velocity_q8),
      .velocity_fresh (velocity_fresh)
   );

   assign rsp_tdata = {3'b000, velocity_fresh, velocity_q8, phase, coil_on};

endmodule

>>> rtl/core/cpgv_ctrl.sv
// Sequencing controller for the coil pulse and gate velocity block.
// Runs the request handshake, the divider iterations and the result register.
// Depends on cpgv_pkg.
module cpgv_ctrl #(
   parameter int unsigned DIV_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  cpgv_pkg::status_type  status,
   output cpgv_pkg::cmd_type     cmd
);

   localparam int unsigned CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.step = 1'b1;
               if (status.calc_due) begin
                  cmd.div_load = 1'b1;
                  cnt_in       = '0;
                  state_in     = ST_DIV;
               end else begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               cmd.div_done = 1'b1;
               state_in     = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("controller stayed idle after taking a request");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == CNT_LAST) |=> (state_ff == ST_WAIT))
      else $error("divider did not finish after its last step");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("result register loaded without raising valid");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.step, cmd.div_step, cmd.load_out}))
      else $error("controller issued conflicting commands");

endmodule

>>> rtl/core/cpgv_datapath.sv
// Datapath for the coil pulse and gate velocity block: configuration
// registers, phase machine state, timestamps, serial divider and result register.
// Depends on cpgv_pkg.
module cpgv_datapath #(
   parameter int unsigned TIME_WIDTH             = 32,
   parameter int unsigned VELOCITY_FRACTION_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [cpgv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cpgv_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                button_pressed,
   input  logic                                gate1_blocked,
   input  logic                                gate2_blocked,
   input  cpgv_pkg::cmd_type                   cmd,
   output cpgv_pkg::status_type                status,
   output logic                                coil_on,
   output logic [cpgv_pkg::PHASE_W-1:0]        phase,
   output logic [cpgv_pkg::VEL_W-1:0]          velocity_q8,
   output logic                                velocity_fresh
);

   localparam int unsigned NUM_W = 8 + VELOCITY_FRACTION_BITS;
   localparam int unsigned DW    = ((TIME_WIDTH > NUM_W) ? TIME_WIDTH : NUM_W) + 1;
   localparam int unsigned QX_W  = NUM_W + cpgv_pkg::VEL_W;

   logic [15:0]                    on_time_ff;
   logic [7:0]                     spacing_ff;
   logic [cpgv_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic [TIME_WIDTH-1:0]          tick_ff, fire_ff, fire_in, g1t_ff, g1t_in, g2t_ff, g2t_in;
   logic [1:0]                     cap_ff, cap_in;
   logic                           coil_ff, coil_in;
   logic [cpgv_pkg::VEL_W-1:0]     vel_ff;
   logic                           fresh_ff;
   logic [DW-1:0]                  rem_ff, den_ff, rem_sh, rem_in;
   logic [NUM_W-1:0]               num_ff, quo_ff, quo_in;
   logic                           dzero_ff;
   logic                           out_coil_ff, out_fresh_ff;
   logic [cpgv_pkg::PHASE_W-1:0]   out_phase_ff;
   logic [cpgv_pkg::VEL_W-1:0]     out_vel_ff;
   logic [TIME_WIDTH-1:0]          elapsed, dt;
   logic [QX_W-1:0]                quo_ext;
   logic [cpgv_pkg::VEL_W-1:0]     vel_sat;

   assign elapsed = tick_ff - fire_ff;
   assign dt      = g2t_ff - g1t_ff;
   assign status.calc_due = (phase_ff == cpgv_pkg::PH_CALC) && (cap_ff == 2'b11);

   always_comb begin
      phase_in = phase_ff;
      fire_in  = fire_ff;
      g1t_in   = g1t_ff;
      g2t_in   = g2t_ff;
      cap_in   = cap_ff;
      coil_in  = coil_ff;
      case (phase_ff)
         cpgv_pkg::PH_IDLE: begin
            if (button_pressed) begin
               coil_in  = 1'b1;
               fire_in  = tick_ff;
               phase_in = cpgv_pkg::PH_FIRING;
            end
            if (gate1_blocked) begin
               g1t_in   = tick_ff;
               cap_in   = cap_ff | 2'b01;
               phase_in = cpgv_pkg::PH_WAITING;
            end
         end
         cpgv_pkg::PH_FIRING: begin
            if (elapsed >= TIME_WIDTH'(on_time_ff)) begin
               phase_in = cpgv_pkg::PH_STOPPED;
            end
            if (gate1_blocked) begin
               coil_in  = 1'b0;
               g1t_in   = tick_ff;
               cap_in   = cap_ff | 2'b01;
               phase_in = cpgv_pkg::PH_WAITING;
            end
         end
         cpgv_pkg::PH_STOPPED: begin
            coil_in = 1'b0;
            if (gate1_blocked) begin
               g1t_in   = tick_ff;
               cap_in   = cap_ff | 2'b01;
               phase_in = cpgv_pkg::PH_WAITING;
            end
            if (!button_pressed) begin
               phase_in = cpgv_pkg::PH_IDLE;
            end
         end
         cpgv_pkg::PH_WAITING: begin
            if (gate2_blocked) begin
               g2t_in   = tick_ff;
               cap_in   = cap_ff | 2'b10;
               phase_in = cpgv_pkg::PH_CALC;
            end
         end
         cpgv_pkg::PH_CALC: begin
            if (cap_ff == 2'b11) begin
               cap_in = 2'b00;
            end
            if (!gate2_blocked) begin
               phase_in = cpgv_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = cpgv_pkg::PH_IDLE;
         end
      endcase
   end

   // Restoring division: one quotient bit per step, numerator bits shifted in from the top.
   always_comb begin
      rem_sh = {rem_ff[DW-2:0], num_ff[NUM_W-1]};
      if (rem_sh >= den_ff) begin
         rem_in = rem_sh - den_ff;
         quo_in = {quo_ff[NUM_W-2:0], 1'b1};
      end else begin
         rem_in = rem_sh;
         quo_in = {quo_ff[NUM_W-2:0], 1'b0};
      end
      quo_ext = QX_W'(quo_in);
      if (dzero_ff || (quo_ext > QX_W'(cpgv_pkg::VEL_MAX))) begin
         vel_sat = cpgv_pkg::VEL_MAX;
      end else begin
         vel_sat = quo_ext[cpgv_pkg::VEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_time_ff <= cpgv_pkg::ON_TIME_RESET;
         spacing_ff <= cpgv_pkg::SPACING_RESET;
         phase_ff   <= cpgv_pkg::PH_IDLE;
         tick_ff    <= '0;
         fire_ff    <= '0;
         g1t_ff     <= '0;
         g2t_ff     <= '0;
         cap_ff     <= 2'b00;
         coil_ff    <= 1'b0;
         vel_ff     <= '0;
         fresh_ff   <= 1'b0;
      end else begin
         if (csr_write && (csr_index == cpgv_pkg::REG_ON_TIME)) begin
            on_time_ff <= csr_wdata;
         end
         if (csr_write && (csr_index == cpgv_pkg::REG_SPACING)) begin
            spacing_ff <= csr_wdata[7:0];
         end
         if (cmd.step) begin
            phase_ff <= phase_in;
            tick_ff  <= tick_ff + 1'b1;
            fire_ff  <= fire_in;
            g1t_ff   <= g1t_in;
            g2t_ff   <= g2t_in;
            cap_ff   <= cap_in;
            coil_ff  <= coil_in;
            fresh_ff <= 1'b0;
         end
         if (cmd.div_done) begin
            vel_ff   <= vel_sat;
            fresh_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff   <= '0;
         quo_ff   <= '0;
         den_ff   <= DW'(dt);
         num_ff   <= NUM_W'(spacing_ff) << VELOCITY_FRACTION_BITS;
         dzero_ff <= (dt == '0);
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         num_ff <= num_ff << 1;
      end
      if (cmd.load_out) begin
         out_coil_ff  <= coil_ff;
         out_phase_ff <= phase_ff;
         out_vel_ff   <= vel_ff;
         out_fresh_ff <= fresh_ff;
      end
   end

   assign coil_on        = out_coil_ff;
   assign phase          = out_phase_ff;
   assign velocity_q8    = out_vel_ff;
   assign velocity_fresh = out_fresh_ff;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for coil_pulse_and_gate_velocity_fsm: directed and random shot
// sequences of ticks, each response checked against a cycle-free model of the phase machine.
// Depends on cpgv_pkg and the RTL under rtl/core.
module tb_top;

   localparam int unsigned FRAC_BITS     = 8;
   localparam int unsigned LIMIT_CYCLES  = 500000;
   localparam int unsigned ITEMS_PER_RUN = 40;
   localparam logic [cpgv_pkg::CSR_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
   localparam logic [cpgv_pkg::CSR_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

   typedef struct packed {
      logic [4:0] pad;
      logic       gate2;
      logic       gate1;
      logic       button;
   } tick_word_type;

   typedef struct packed {
      logic [2:0]  pad;
      logic        fresh;
      logic [15:0] velocity;
      logic [2:0]  phase;
      logic        coil;
   } status_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [cpgv_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [cpgv_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   tick_word_type   tick_queue[$];
   status_word_type status_queue[$];
   status_word_type got_status;
   status_word_type want_status;
   int unsigned     idle_pct = 0;
   int unsigned     stall_pct = 0;
   int unsigned     error_count = 0;
   int unsigned     cycle_count = 0;

   // Model state and register copies.
   logic [15:0]                  on_time = cpgv_pkg::ON_TIME_RESET;
   logic [7:0]                   spacing = cpgv_pkg::SPACING_RESET;
   logic [cpgv_pkg::PHASE_W-1:0] phase_q = cpgv_pkg::PH_IDLE;
   logic [31:0]                  tick_now = '0;
   logic [31:0]                  fire_t = '0;
   logic [31:0]                  gate1_t = '0;
   logic [31:0]                  gate2_t = '0;
   logic [1:0]                   capture_q = '0;
   logic                         coil_q = 1'b0;
   logic [15:0]                  velocity_q = '0;

   coil_pulse_and_gate_velocity_fsm #(
      .TIME_WIDTH(32),
      .VELOCITY_FRACTION_BITS(FRAC_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic status_word_type advance_tick(input logic button, input logic gate1,
                                                    input logic gate2);
      status_word_type result;
      logic [31:0]     interval;
      logic [31:0]     quotient;
      result = '0;
      case (phase_q)
         cpgv_pkg::PH_IDLE: begin
            if (button) begin
               coil_q  = 1'b1;
               fire_t  = tick_now;
               phase_q = cpgv_pkg::PH_FIRING;
            end
            if (gate1) begin
               gate1_t      = tick_now;
               capture_q[0] = 1'b1;
               phase_q      = cpgv_pkg::PH_WAITING;
            end
         end
         cpgv_pkg::PH_FIRING: begin
            if (tick_now - fire_t >= 32'(on_time)) phase_q = cpgv_pkg::PH_STOPPED;
            if (gate1) begin
               coil_q       = 1'b0;
               gate1_t      = tick_now;
               capture_q[0] = 1'b1;
               phase_q      = cpgv_pkg::PH_WAITING;
            end
         end
         cpgv_pkg::PH_STOPPED: begin
            coil_q = 1'b0;
            if (gate1) begin
               gate1_t      = tick_now;
               capture_q[0] = 1'b1;
               phase_q      = cpgv_pkg::PH_WAITING;
            end
            if (!button) phase_q = cpgv_pkg::PH_IDLE;
         end
         cpgv_pkg::PH_WAITING: begin
            if (gate2) begin
               gate2_t      = tick_now;
               capture_q[1] = 1'b1;
               phase_q      = cpgv_pkg::PH_CALC;
            end
         end
         cpgv_pkg::PH_CALC: begin
            if (capture_q == 2'b11) begin
               interval = gate2_t - gate1_t;
               if (interval == 0) begin
                  velocity_q = cpgv_pkg::VEL_MAX;
               end else begin
                  quotient   = (32'(spacing) << FRAC_BITS) / interval;
                  velocity_q = (quotient > 32'(cpgv_pkg::VEL_MAX)) ? cpgv_pkg::VEL_MAX
                                                                   : quotient[15:0];
               end
               result.fresh = 1'b1;
               capture_q    = '0;
            end
            if (!gate2) phase_q = cpgv_pkg::PH_IDLE;
         end
         default: begin
            phase_q = cpgv_pkg::PH_IDLE;
         end
      endcase
      tick_now        = tick_now + 32'd1;
      result.coil     = coil_q;
      result.phase    = phase_q;
      result.velocity = velocity_q;
      return result;
   endfunction

   function automatic void add_tick(input logic button, input logic gate1, input logic gate2);
      tick_word_type word;
      word        = '0;
      word.button = button;
      word.gate1  = gate1;
      word.gate2  = gate2;
      tick_queue.push_back(word);
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   // One shot: rest, fire, gate 1, flight, gate 2, release; sometimes plain noise.
   task automatic queue_shot(output int unsigned count);
      int unsigned n;
      count = 0;
      if ($urandom_range(99) < 20) begin
         n = $urandom_range(1, 8);
         repeat (n) add_tick(rand_bit(), rand_bit(), rand_bit());
         count = n;
      end else begin
         n = $urandom_range(0, 3);
         repeat (n) add_tick(1'b0, 1'b0, rand_bit());
         count += n;
         n = $urandom_range(1, 40);
         repeat (n) add_tick(1'b1, 1'b0, rand_bit());
         count += n;
         n = $urandom_range(1, 2);
         repeat (n) add_tick(rand_bit(), 1'b1, 1'b0);
         count += n;
         n = $urandom_range(0, 30);
         repeat (n) add_tick(rand_bit(), rand_bit(), 1'b0);
         count += n;
         n = $urandom_range(1, 4);
         repeat (n) add_tick(rand_bit(), rand_bit(), 1'b1);
         count += n;
         add_tick(1'b0, rand_bit(), 1'b0);
         count += 1;
      end
   endtask

   task automatic write_register(input logic [cpgv_pkg::CSR_IDX_W-1:0] index,
                                 input logic [cpgv_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == cpgv_pkg::REG_ON_TIME) on_time = value;
      else if (index == cpgv_pkg::REG_SPACING) spacing = value[7:0];
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      while (tick_queue.size() != 0 || req_tvalid || status_queue.size() != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            status_queue.push_back(advance_tick(req_tdata[0], req_tdata[1], req_tdata[2]));
         if (!req_tvalid || req_tready) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= tick_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = rsp_tdata;
         if (status_queue.size() == 0) begin
            $display("%0t: response with none expected, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want_status = status_queue.pop_front();
            if (got_status.coil !== want_status.coil || got_status.phase !== want_status.phase
                || got_status.velocity !== want_status.velocity
                || got_status.fresh !== want_status.fresh) begin
               $display("%0t: expected c=%0d p=%0d v=%0d f=%0d, actual c=%0d p=%0d v=%0d f=%0d",
                        $time, want_status.coil, want_status.phase, want_status.velocity,
                        want_status.fresh, got_status.coil, got_status.phase,
                        got_status.velocity, got_status.fresh);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned run;
      int unsigned count;
      int unsigned shot_len;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Default registers: fire and gate 1 together, then a plain shot.
      add_tick(1'b0, 1'b0, 1'b0);
      add_tick(1'b1, 1'b1, 1'b0);
      add_tick(1'b0, 1'b0, 1'b1);
      add_tick(1'b0, 1'b0, 1'b1);
      add_tick(1'b0, 1'b0, 1'b1);
      add_tick(1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 1'b0, 1'b1);
      add_tick(1'b1, 1'b0, 1'b0);
      add_tick(1'b0, 1'b1, 1'b0);
      add_tick(1'b1, 1'b1, 1'b0);
      add_tick(1'b0, 1'b1, 1'b1);
      add_tick(1'b0, 1'b0, 1'b0);
      drain();

      // Zero on-time and zero spacing; writes to unused indexes must be ignored.
      write_register(cpgv_pkg::REG_ON_TIME, 16'd0);
      write_register(cpgv_pkg::REG_SPACING, 16'd0);
      write_register(REG_UNUSED_LO, 16'hFFFF);
      write_register(REG_UNUSED_HI, 16'h1234);
      add_tick(1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 1'b0, 1'b1);
      add_tick(1'b0, 1'b1, 1'b0);
      add_tick(1'b0, 1'b0, 1'b0);
      add_tick(1'b1, 1'b1, 1'b0);
      add_tick(1'b0, 1'b0, 1'b1);
      add_tick(1'b0, 1'b0, 1'b0);
      add_tick(1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 1'b0, 1'b0);
      add_tick(1'b1, 1'b1, 1'b0);
      add_tick(1'b1, 1'b0, 1'b1);
      add_tick(1'b1, 1'b0, 1'b0);
      drain();

      write_register(cpgv_pkg::REG_SPACING, 16'd255);
      write_register(cpgv_pkg::REG_ON_TIME, 16'd1);
      add_tick(1'b0, 1'b1, 1'b0);
      add_tick(1'b0, 1'b0, 1'b1);
      add_tick(1'b0, 1'b1, 1'b0);
      drain();

      for (run = 0; run < 8; run++) begin
         case (run % 4)
            0: write_register(cpgv_pkg::REG_ON_TIME, 16'($urandom_range(1, 40)));
            1: write_register(cpgv_pkg::REG_ON_TIME, 16'hFFFF);
            2: write_register(cpgv_pkg::REG_ON_TIME, 16'($urandom_range(0, 1)));
            default: write_register(cpgv_pkg::REG_ON_TIME, 16'($urandom_range(2, 20)));
         endcase
         case (run)
            1: write_register(cpgv_pkg::REG_SPACING, 16'd1);
            2: write_register(cpgv_pkg::REG_SPACING, 16'd255);
            5: write_register(cpgv_pkg::REG_SPACING, 16'h1F05);
            default: write_register(cpgv_pkg::REG_SPACING, 16'($urandom_range(0, 255)));
         endcase
         case (run % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 75;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 75;
            end
            default: begin
               idle_pct  = 22;
               stall_pct = 22;
            end
         endcase
         count = 0;
         while (count < ITEMS_PER_RUN) begin
            queue_shot(shot_len);
            count += shot_len;
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/cpgv_pkg.sv
rtl/core/cpgv_ctrl.sv
rtl/core/cpgv_datapath.sv
rtl/core/coil_pulse_and_gate_velocity_fsm.sv
sim/tb_top.sv
